[rtl/rrts_pkg.sv]
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

    localparam int DEF_NUM_TASKS = 8;
    localparam int OP_W          = 3;
    localparam int TASK_W        = 3;
    localparam int TICK_W        = 16;
    localparam int SP_W          = 8;
    localparam int MASK_W        = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_DELAY   = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_LOAD    = 3'd4
    } t_op;

    // Commands from the sequencer to the sleep timer bank.
    typedef struct packed {
        logic step;   // decrement the addressed counter if nonzero
        logic load;   // write the addressed counter
    } t_timer_cmd;

endpackage

[rtl/round_robin_task_scheduler_core.sv]
// Top level of the round-robin task scheduler: sequencer, ready bits and saved pointers.
//
// One request is taken at a time and gives one result. A tick walks the sleep counters
// through a single shared decrementer, one task per cycle, and then searches while a switch
// is pending. Delay and suspend with no switch pending, and a resume while one is pending,
// search round-robin one task per cycle. Load, an ignored request and other codes go
// straight to the output register without a search.
// The input stalls while a request is at work; a finished result waits in the output
// register, and the next request is accepted meanwhile. No clearing pass after reset.
module round_robin_task_scheduler_core #(
    parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rrts_pkg::OP_W-1:0]   i_op,
    input  logic [rrts_pkg::TASK_W-1:0] i_task_index,
    input  logic [rrts_pkg::TICK_W-1:0] i_delay_ticks,
    input  logic [rrts_pkg::SP_W-1:0]   i_stack_pointer,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rrts_pkg::TASK_W-1:0] o_current_task,
    output logic [rrts_pkg::SP_W-1:0]   o_restore_sp,
    output logic                        o_switched,
    output logic                        o_idle,
    output logic [rrts_pkg::MASK_W-1:0] o_ready_mask
);

    localparam int IDX_W  = $clog2(NUM_TASKS);
    localparam int WIDE_W = (NUM_TASKS > rrts_pkg::MASK_W) ? NUM_TASKS : rrts_pkg::MASK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TICK   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state                       r_state;
    logic [IDX_W-1:0]             r_running;
    logic                         r_pending;
    logic [NUM_TASKS-1:0]         r_ready;
    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             r_steps;
    logic                         r_switched;
    logic                         r_out_valid;
    logic [rrts_pkg::SP_W-1:0]    r_ptr_mem [NUM_TASKS];
    logic [rrts_pkg::SP_W-1:0]    r_rd_sp;
    logic [rrts_pkg::TASK_W-1:0]  r_out_task;
    logic [rrts_pkg::SP_W-1:0]    r_out_sp;
    logic                         r_out_switched;
    logic                         r_out_idle;
    logic [rrts_pkg::MASK_W-1:0]  r_out_mask;

    logic                         w_accept;
    logic                         w_tidx_ok;
    logic                         w_emit;
    logic                         w_expire;
    logic                         w_ptr_we;
    logic [IDX_W-1:0]             w_ptr_addr;
    logic [IDX_W-1:0]             w_timer_idx;
    logic [WIDE_W-1:0]            w_ready_wide;
    rrts_pkg::t_timer_cmd         w_timer_cmd;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_tidx_ok   = int'(i_task_index) < NUM_TASKS;
    assign w_emit      = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // Timer bank: load on an accepted delay with no switch pending, step while walking for a tick.
    assign w_timer_cmd.load = w_accept && (i_op == rrts_pkg::OP_DELAY) && !r_pending;
    assign w_timer_cmd.step = (r_state == ST_TICK);
    assign w_timer_idx      = (r_state == ST_IDLE) ? r_running : r_idx;

    rrts_sleep_timer #(
        .NUM_TASKS (NUM_TASKS)
    ) u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_timer_cmd),
        .i_idx        (w_timer_idx),
        .i_load_value (i_delay_ticks),
        .o_expire     (w_expire)
    );

    // Saved stack pointers: written on an accepted load, delay or suspend, read at the search candidate.
    assign w_ptr_we   = w_accept &&
                        (((i_op == rrts_pkg::OP_LOAD) && w_tidx_ok) ||
                         (((i_op == rrts_pkg::OP_DELAY) || (i_op == rrts_pkg::OP_SUSPEND)) &&
                          !r_pending));
    assign w_ptr_addr = (i_op == rrts_pkg::OP_LOAD) ? IDX_W'(i_task_index) : r_running;

    always_ff @(posedge i_clk) begin
        if (w_ptr_we) begin
            r_ptr_mem[w_ptr_addr] <= i_stack_pointer;
        end
        r_rd_sp <= r_ptr_mem[r_idx];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= '0;
            r_pending   <= 1'b0;
            r_ready     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_expire) begin
                r_ready[r_idx] <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_switched <= 1'b0;
                        unique case (i_op) inside
                            rrts_pkg::OP_TICK: begin
                                r_idx   <= '0;
                                r_state <= ST_TICK;
                            end
                            rrts_pkg::OP_DELAY, rrts_pkg::OP_SUSPEND: begin
                                if (!r_pending) begin
                                    r_ready[r_running] <= 1'b0;
                                    r_pending          <= 1'b1;
                                    r_idx              <= next_idx(r_running);
                                    r_steps            <= '0;
                                    r_state            <= ST_SEARCH;
                                end else begin
                                    r_state <= ST_EMIT;
                                end
                            end
                            rrts_pkg::OP_RESUME: begin
                                if (w_tidx_ok) begin
                                    r_ready[IDX_W'(i_task_index)] <= 1'b1;
                                end
                                if (r_pending) begin
                                    r_idx   <= next_idx(r_running);
                                    r_steps <= '0;
                                    r_state <= ST_SEARCH;
                                end else begin
                                    r_state <= ST_EMIT;
                                end
                            end
                            default: begin
                                r_state <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    if (r_idx == LAST_IDX) begin
                        if (r_pending) begin
                            r_idx   <= next_idx(r_running);
                            r_steps <= '0;
                            r_state <= ST_SEARCH;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SEARCH: begin
                    // hold r_idx on a hit so the pointer read stays on the winner
                    if (r_ready[r_idx]) begin
                        r_running  <= r_idx;
                        r_pending  <= 1'b0;
                        r_switched <= 1'b1;
                        r_state    <= ST_EMIT;
                    end else if (r_steps == LAST_IDX) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx   <= next_idx(r_idx);
                        r_steps <= r_steps + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_ready_wide = WIDE_W'(r_ready);

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_task     <= rrts_pkg::TASK_W'(r_running);
            r_out_sp       <= r_switched ? r_rd_sp : '0;
            r_out_switched <= r_switched;
            r_out_idle     <= r_pending;
            r_out_mask     <= w_ready_wide[rrts_pkg::MASK_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_current_task = r_out_task;
    assign o_restore_sp   = r_out_sp;
    assign o_switched     = r_out_switched;
    assign o_idle         = r_out_idle;
    assign o_ready_mask   = r_out_mask;

    a_hit_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) && r_ready[r_idx] |=> !r_pending && (r_state == ST_EMIT))
        else $error("search hit did not clear the pending switch");

    a_switch_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switched |-> !o_idle)
        else $error("result reports a switch and idle together");

    a_tick_keeps_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |=> $stable(r_pending) && $stable(r_running))
        else $error("counter walk changed the running task or pending flag");

    a_call_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !r_pending &&
        ((i_op == rrts_pkg::OP_DELAY) || (i_op == rrts_pkg::OP_SUSPEND))
        |=> r_pending && (r_state == ST_SEARCH))
        else $error("delay or suspend did not start a pending switch");

endmodule

[rtl/rrts_sleep_timer.sv]
// Sleep counter bank with one shared decrementer, one task visited per cycle.
module rrts_sleep_timer #(
    parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS,
    localparam int IDX_W    = $clog2(NUM_TASKS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rrts_pkg::t_timer_cmd       i_cmd,
    input  logic [IDX_W-1:0]           i_idx,
    input  logic [rrts_pkg::TICK_W-1:0] i_load_value,
    output logic                       o_expire
);

    logic [rrts_pkg::TICK_W-1:0] r_count [NUM_TASKS];
    logic [rrts_pkg::TICK_W-1:0] w_cur;
    logic [rrts_pkg::TICK_W-1:0] w_dec;

    assign w_cur    = r_count[i_idx];
    assign w_dec    = w_cur - 1'b1;
    // a counter stepping from one down to zero readies its task
    assign o_expire = i_cmd.step && (w_cur == rrts_pkg::TICK_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_cmd.load) begin
            r_count[i_idx] <= i_load_value;
        end else if (i_cmd.step && (w_cur != '0)) begin
            r_count[i_idx] <= w_dec;
        end
    end

endmodule

[tb/sv/round_robin_task_scheduler_core_test.sv]
// Self-checking testbench of the round-robin task scheduler core.
module round_robin_task_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TASKS    = rrts_pkg::DEF_NUM_TASKS;
    localparam int RANDOM_ITEMS = 426;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;

    // Codes outside the defined operations; the block must leave its state alone.
    localparam logic [rrts_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [rrts_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [rrts_pkg::TASK_W-1:0] task_id;
        logic [rrts_pkg::SP_W-1:0]   sp;
        logic                        switched;
        logic                        idle;
        logic [rrts_pkg::MASK_W-1:0] mask;
    } t_sched_result;

    typedef struct packed {
        logic [rrts_pkg::OP_W-1:0]   op;
        logic [rrts_pkg::TASK_W-1:0] idx;
        logic [rrts_pkg::TICK_W-1:0] ticks;
        logic [rrts_pkg::SP_W-1:0]   sp;
        logic                        typed;
        t_sched_result               res;
    } t_sched_row;

    // Typed results: all quiet, and a switch left waiting with nothing ready.
    localparam t_sched_result RES_ZERO = '0;
    localparam t_sched_result RES_IDLE = {3'd0, 8'h00, 1'b0, 1'b1, 8'h00};

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [rrts_pkg::OP_W-1:0]   in_op = '0;
    logic [rrts_pkg::TASK_W-1:0] in_task = '0;
    logic [rrts_pkg::TICK_W-1:0] in_ticks = '0;
    logic [rrts_pkg::SP_W-1:0]   in_sp = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [rrts_pkg::TASK_W-1:0] out_task;
    logic [rrts_pkg::SP_W-1:0]   out_sp;
    logic                        out_switched;
    logic                        out_idle;
    logic [rrts_pkg::MASK_W-1:0] out_mask;

    // Scheduler state as the checker sees it.
    logic [rrts_pkg::TASK_W-1:0] model_running = '0;
    logic [NUM_TASKS-1:0]        model_ready = '0;
    logic [rrts_pkg::TICK_W-1:0] model_sleep [NUM_TASKS];
    logic [rrts_pkg::SP_W-1:0]   model_sp [NUM_TASKS];
    logic                        model_pending = 1'b0;

    t_sched_result expected_results[$];
    t_sched_row    directed_rows[$];

    int  cycle_count = 0;
    int  fail_count = 0;
    int  report_count = 0;
    int  checked_count = 0;
    int  switch_count = 0;
    int  idle_count = 0;
    int  op_seen [8];
    bit  hold_req = 1'b0;
    bit  quiet = 1'b0;

    round_robin_task_scheduler_core #(
        .NUM_TASKS(NUM_TASKS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (in_op),
        .i_task_index   (in_task),
        .i_delay_ticks  (in_ticks),
        .i_stack_pointer(in_sp),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_current_task (out_task),
        .o_restore_sp   (out_sp),
        .o_switched     (out_switched),
        .o_idle         (out_idle),
        .o_ready_mask   (out_mask)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the scheduler state and return the result it gives.
    function automatic t_sched_result schedule_request(
        input logic [rrts_pkg::OP_W-1:0]   op,
        input logic [rrts_pkg::TASK_W-1:0] idx,
        input logic [rrts_pkg::TICK_W-1:0] ticks,
        input logic [rrts_pkg::SP_W-1:0]   sp);
        t_sched_result r;
        bit attempt;
        bit found;
        int nxt;
        int slot;
        attempt = 1'b0;
        found = 1'b0;
        nxt = 0;
        case (op) inside
            rrts_pkg::OP_TICK: begin
                for (int t = 0; t < NUM_TASKS; t++) begin
                    if (model_sleep[t] != '0) begin
                        model_sleep[t] = model_sleep[t] - 1'b1;
                        if (model_sleep[t] == '0)
                            model_ready[t] = 1'b1;
                    end
                end
                attempt = model_pending;
            end
            rrts_pkg::OP_DELAY, rrts_pkg::OP_SUSPEND: begin
                // no running caller while a switch is pending: drop the request
                if (!model_pending) begin
                    model_sp[model_running] = sp;
                    model_ready[model_running] = 1'b0;
                    if (op == rrts_pkg::OP_DELAY)
                        model_sleep[model_running] = ticks;
                    model_pending = 1'b1;
                    attempt = 1'b1;
                end
            end
            rrts_pkg::OP_RESUME: begin
                if (idx < NUM_TASKS)
                    model_ready[idx] = 1'b1;
                attempt = model_pending;
            end
            rrts_pkg::OP_LOAD: begin
                if (idx < NUM_TASKS)
                    model_sp[idx] = sp;
            end
            default: begin
            end
        endcase
        if (attempt) begin
            // search from the next task, the running one last
            for (int k = 1; k <= NUM_TASKS; k++) begin
                slot = (model_running + k) % NUM_TASKS;
                if (!found && model_ready[slot]) begin
                    found = 1'b1;
                    nxt = slot;
                end
            end
            if (found) begin
                model_running = rrts_pkg::TASK_W'(nxt);
                model_pending = 1'b0;
            end
        end
        r.task_id  = model_running;
        r.sp       = found ? model_sp[model_running] : '0;
        r.switched = found;
        r.idle     = model_pending;
        r.mask     = rrts_pkg::MASK_W'(model_ready);
        return r;
    endfunction

    task automatic add_row(input logic [rrts_pkg::OP_W-1:0]   op,
                           input logic [rrts_pkg::TASK_W-1:0] idx,
                           input logic [rrts_pkg::TICK_W-1:0] ticks,
                           input logic [rrts_pkg::SP_W-1:0]   sp,
                           input logic typed, input t_sched_result res);
        directed_rows.push_back({op, idx, ticks, sp, typed, res});
    endtask

    // Offer one request, hold it until taken, then record what it should return.
    task automatic issue_request(input logic [rrts_pkg::OP_W-1:0]   op,
                                 input logic [rrts_pkg::TASK_W-1:0] idx,
                                 input logic [rrts_pkg::TICK_W-1:0] ticks,
                                 input logic [rrts_pkg::SP_W-1:0]   sp,
                                 input logic typed, input t_sched_result typed_res);
        t_sched_result predicted;
        int gap;
        if (!quiet && !hold_req && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_task  <= idx;
        in_ticks <= ticks;
        in_sp    <= sp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = schedule_request(op, idx, ticks, sp);
        expected_results.push_back(typed ? typed_res : predicted);
        op_seen[op]++;
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        int n;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (n - 1) @(posedge clk);
            end else begin
                n = $urandom_range(1, 20);
                out_stall <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_sched_result got;
        t_sched_result want;
        if (rst_n && out_valid && !out_stall) begin
            got = {out_task, out_sp, out_switched, out_idle, out_mask};
            checked_count++;
            if (got.switched)
                switch_count++;
            if (got.idle)
                idle_count++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("unexpected result: task %0d sp %02h sw %0b idle %0b mask %02h",
                             got.task_id, got.sp, got.switched, got.idle, got.mask);
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("mismatch at result %0d (exp/got): task %0d/%0d sp %02h/%02h",
                                 checked_count, want.task_id, got.task_id, want.sp, got.sp);
                        $display("  sw %0b/%0b idle %0b/%0b mask %02h/%02h",
                                 want.switched, got.switched, want.idle, got.idle,
                                 want.mask, got.mask);
                    end
                end
            end
        end
    end

    initial begin
        int sent;
        int pick;
        int spare;
        logic [rrts_pkg::OP_W-1:0]   op;
        logic [rrts_pkg::TASK_W-1:0] idx;
        logic [rrts_pkg::TICK_W-1:0] ticks;
        logic [rrts_pkg::SP_W-1:0]   sp;
        sent = 0;
        spare = 0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            model_sleep[t] = '0;
            model_sp[t] = '0;
        end
        foreach (op_seen[c])
            op_seen[c] = 0;

        // Load every pointer first so no switch ever lands on an unwritten one.
        add_row(rrts_pkg::OP_LOAD, 3'd0, 16'h0000, 8'h00, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd1, 16'hFFFF, 8'hFF, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd2, 16'h0000, 8'h12, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd3, 16'h0000, 8'h34, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd4, 16'h0000, 8'h56, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd5, 16'h0000, 8'h78, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd6, 16'h0000, 8'h9A, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_LOAD, 3'd7, 16'h0000, 8'hBC, 1'b1, RES_ZERO);
        add_row(OP_SPARE_LO, 3'd0, 16'h0000, 8'h00, 1'b1, RES_ZERO);
        add_row(OP_SPARE_HI, 3'd7, 16'hFFFF, 8'hFF, 1'b1, RES_ZERO);
        add_row(rrts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00, 1'b1, RES_ZERO);
        // suspend with nothing ready leaves the switch pending
        add_row(rrts_pkg::OP_SUSPEND, 3'd0, 16'h0000, 8'hA5, 1'b1, RES_IDLE);
        add_row(rrts_pkg::OP_DELAY, 3'd0, 16'h0005, 8'h11, 1'b1, RES_IDLE);
        add_row(rrts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00, 1'b1, RES_IDLE);
        // only the former task is ready: switch back onto it
        add_row(rrts_pkg::OP_RESUME, 3'd0, 16'h0000, 8'h00, 1'b1,
                {3'd0, 8'hA5, 1'b1, 1'b0, 8'h01});
        add_row(rrts_pkg::OP_DELAY, 3'd0, 16'hFFFF, 8'h00, 1'b1, RES_IDLE);
        add_row(rrts_pkg::OP_RESUME, 3'd3, 16'h0000, 8'h00, 1'b0, RES_ZERO);
        // resume a sleeping task while its counter keeps running
        add_row(rrts_pkg::OP_RESUME, 3'd0, 16'h0000, 8'h00, 1'b0, RES_ZERO);
        add_row(rrts_pkg::OP_DELAY, 3'd5, 16'h0001, 8'h3C, 1'b0, RES_ZERO);
        add_row(rrts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00, 1'b0, RES_ZERO);
        add_row(rrts_pkg::OP_RESUME, 3'd5, 16'h0000, 8'h00, 1'b0, RES_ZERO);
        add_row(rrts_pkg::OP_SUSPEND, 3'd2, 16'h1234, 8'hC3, 1'b0, RES_ZERO);
        add_row(rrts_pkg::OP_DELAY, 3'd0, 16'h0000, 8'h7E, 1'b0, RES_ZERO);
        add_row(rrts_pkg::OP_TICK, 3'd7, 16'h0000, 8'h00, 1'b0, RES_ZERO);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
            issue_request(directed_rows[n].op, directed_rows[n].idx, directed_rows[n].ticks,
                          directed_rows[n].sp, directed_rows[n].typed, directed_rows[n].res);

        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 32)
                op = rrts_pkg::OP_TICK;
            else if (pick < 50)
                op = rrts_pkg::OP_DELAY;
            else if (pick < 58)
                op = rrts_pkg::OP_SUSPEND;
            else if (pick < 80)
                op = rrts_pkg::OP_RESUME;
            else if (pick < 92)
                op = rrts_pkg::OP_LOAD;
            else
                op = rrts_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            idx = rrts_pkg::TASK_W'($urandom_range(0, NUM_TASKS - 1));
            sp = rrts_pkg::SP_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            // mostly short sleeps so timers expire; sometimes zero or any length
            if (pick < 7)
                ticks = rrts_pkg::TICK_W'($urandom_range(1, 6));
            else if (pick == 7)
                ticks = '0;
            else
                ticks = rrts_pkg::TICK_W'($urandom_range(0, 16'hFFFF));
            if (sent == HOLD_AT)
                hold_req = 1'b1;
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            issue_request(op, idx, ticks, sp, 1'b0, RES_ZERO);
            sent++;
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
            spare += op_seen[c];
        $display("requests: %0d tick, %0d delay, %0d suspend, %0d resume, %0d load, %0d spare",
                 op_seen[rrts_pkg::OP_TICK], op_seen[rrts_pkg::OP_DELAY],
                 op_seen[rrts_pkg::OP_SUSPEND], op_seen[rrts_pkg::OP_RESUME],
                 op_seen[rrts_pkg::OP_LOAD], spare);
        $display("results checked %0d, task switches %0d, idle results %0d, failures %0d",
                 checked_count, switch_count, idle_count, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/rrts_pkg.sv
rtl/rrts_sleep_timer.sv
rtl/round_robin_task_scheduler_core.sv
tb/sv/round_robin_task_scheduler_core_test.sv
